// File: rtl/bpmd_pkg.sv
// ----------------------------------------------------------------------------
// bpmd_pkg: shared types and constants for the bidirectional PWM motor drive
// Holds period, divisor and code constants plus the FSM and interface types.
// ----------------------------------------------------------------------------
package bpmd_pkg;

	// last tick count of the PWM period; the counter runs 0..PERIOD_MAX
	localparam int unsigned PERIOD_MAX = 500;
	localparam int unsigned TICK_W     = 9;
	localparam int unsigned MAG_W      = 8;
	localparam int unsigned PROD_W     = MAG_W + TICK_W;
	localparam int unsigned CNT_W      = 5;

	localparam logic [TICK_W-1:0] PERIOD_VAL = TICK_W'(PERIOD_MAX);

	// divisors of the speed mapping
	localparam logic [MAG_W-1:0] DIV_SPAN = 8'd255;
	localparam logic [MAG_W-1:0] DIV_REV  = 8'd128;
	localparam logic [MAG_W-1:0] DIV_FWD  = 8'd127;

	// input command codes
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_SPEED = 1'b1;

	// calibration modes
	localparam logic [1:0] MODE_SPLIT = 2'd0;
	localparam logic [1:0] MODE_REV   = 2'd1;
	localparam logic [1:0] MODE_FWD   = 2'd2;
	localparam logic [1:0] MODE_OFF   = 2'd3;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_CAL_MODE    = 2'd0;
	localparam logic [1:0] REG_CAL_REVERSE = 2'd1;
	localparam logic [1:0] REG_CAL_FORWARD = 2'd2;

	typedef enum logic [1:0] {
		MD_IDLE,
		MD_MUL,
		MD_DIV
	} md_state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SPAN,
		ST_FINAL
	} ctl_state_t;

	// request to the serial multiply-divide unit: quot = a * b / divisor
	typedef struct packed {
		logic              start;
		logic [MAG_W-1:0]  mult_a;
		logic [TICK_W-1:0] mult_b;
		logic [MAG_W-1:0]  divisor;
	} md_req_t;

	typedef struct packed {
		logic              done;
		logic [TICK_W-1:0] quot;
	} md_rsp_t;

	typedef struct packed {
		logic              tick;
		logic              load;
		logic [TICK_W-1:0] cmp_a;
		logic [TICK_W-1:0] cmp_b;
	} pwm_ctl_t;

	typedef struct packed {
		logic              pin_a;
		logic              pin_b;
		logic [TICK_W-1:0] cmp_a;
		logic [TICK_W-1:0] cmp_b;
	} pwm_sts_t;

endpackage

// File: rtl/bpmd_muldiv.sv
// ----------------------------------------------------------------------------
// bpmd_muldiv: bit-serial multiply then restoring divide
// Computes a * b / divisor, one multiplier bit and one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bpmd_muldiv
	import bpmd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	md_state_t state_q, state_n;

	logic [CNT_W-1:0]  cnt_q;
	logic [MAG_W-1:0]  a_q;
	logic [TICK_W-1:0] b_q;
	logic [MAG_W-1:0]  d_q;
	logic [PROD_W-1:0] p_q;
	logic [MAG_W-1:0]  r_q;
	logic              done_q;

	logic              load, mul_en, div_en, finish;
	logic              last;
	logic [TICK_W-1:0] rem_ext;
	logic [TICK_W-1:0] diff;
	logic              ge;
	logic [PROD_W-1:0] addend;

	assign last    = (cnt_q == '0);
	assign rem_ext = {r_q, p_q[PROD_W-1]};
	assign ge      = rem_ext >= {1'b0, d_q};
	assign diff    = rem_ext - {1'b0, d_q};
	assign addend  = a_q[MAG_W-1] ? PROD_W'(b_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= finish;
		end
	end

	always_comb begin
		state_n = state_q;
		load    = 1'b0;
		mul_en  = 1'b0;
		div_en  = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			MD_IDLE: begin
				if (req.start) begin
					load    = 1'b1;
					state_n = MD_MUL;
				end
			end
			MD_MUL: begin
				mul_en = 1'b1;
				if (last) begin
					state_n = MD_DIV;
				end
			end
			MD_DIV: begin
				div_en = 1'b1;
				if (last) begin
					finish  = 1'b1;
					state_n = MD_IDLE;
				end
			end
			default: begin
				state_n = MD_IDLE;
			end
		endcase
	end

	// datapath: shift-add multiply, then shift-subtract divide in place
	always_ff @(posedge clk) begin
		if (load) begin
			a_q   <= req.mult_a;
			b_q   <= req.mult_b;
			d_q   <= req.divisor;
			p_q   <= '0;
			cnt_q <= CNT_W'(MAG_W - 1);
		end else if (mul_en) begin
			p_q <= {p_q[PROD_W-2:0], 1'b0} + addend;
			a_q <= {a_q[MAG_W-2:0], 1'b0};
			if (last) begin
				cnt_q <= CNT_W'(PROD_W - 1);
				r_q   <= '0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else if (div_en) begin
			r_q   <= ge ? diff[MAG_W-1:0] : rem_ext[MAG_W-1:0];
			p_q   <= {p_q[PROD_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = p_q[TICK_W-1:0];

endmodule

// File: rtl/bpmd_pwm.sv
// ----------------------------------------------------------------------------
// bpmd_pwm: period counter, compare values and the two pin levels
// Advances on a tick, takes new compare values on a load.
// ----------------------------------------------------------------------------
module bpmd_pwm
	import bpmd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  pwm_ctl_t ctl,
	output pwm_sts_t sts
);

	logic [TICK_W-1:0] count_q;
	logic [TICK_W-1:0] cmp_a_q, cmp_b_q;
	logic              pin_a_q, pin_b_q;

	logic              wrap;
	logic [TICK_W-1:0] count_n;
	logic              pin_a_n, pin_b_n;

	always_comb begin
		wrap    = count_q >= PERIOD_VAL;
		count_n = wrap ? '0 : count_q + 1'b1;
		pin_a_n = pin_a_q;
		pin_b_n = pin_b_q;
		// clear on match, unless the compare is the full period
		if (count_n == cmp_a_q && cmp_a_q != PERIOD_VAL) begin
			pin_a_n = 1'b0;
		end
		if (count_n == cmp_b_q && cmp_b_q != PERIOD_VAL) begin
			pin_b_n = 1'b0;
		end
		// set at the wrap when the channel is driven at all
		if (wrap && cmp_a_q != '0) begin
			pin_a_n = 1'b1;
		end
		if (wrap && cmp_b_q != '0) begin
			pin_b_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cmp_a_q <= '0;
			cmp_b_q <= '0;
			pin_a_q <= 1'b0;
			pin_b_q <= 1'b0;
		end else if (ctl.tick) begin
			count_q <= count_n;
			pin_a_q <= pin_a_n;
			pin_b_q <= pin_b_n;
		end else if (ctl.load) begin
			cmp_a_q <= ctl.cmp_a;
			cmp_b_q <= ctl.cmp_b;
		end
	end

	assign sts.pin_a = pin_a_q;
	assign sts.pin_b = pin_b_q;
	assign sts.cmp_a = cmp_a_q;
	assign sts.cmp_b = cmp_b_q;

endmodule

// File: rtl/bidirectional_pwm_motor_drive.sv
// ----------------------------------------------------------------------------
// bidirectional_pwm_motor_drive: two-pin PWM generator for an H-bridge
// Maps a signed speed to one channel's compare value and runs the PWM.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake           payload
//  -------  ---------  ------------------  -------------------------------
//  in       sink       in_valid/in_stall   command, speed
//  out      source     out_valid/out_stall drive_a, drive_b, duty_a, duty_b
//  cfg      APB slave  psel/penable/pready paddr[3:0], pwdata, prdata
//
//  A tick transfer's result is valid in the cycle after it is taken.
//  A set-speed transfer runs the serial multiply-divide unit, a pass taking
//  8 multiplier bits, 17 quotient bits and a hand-over: one pass in modes 1
//  and 2, two in mode 0 (span, scale; none at zero speed), none in mode 3.
//  The block takes the next transfer once the result is gone or leaving.
//  Reset clears the counter, both compares, both pins and the registers.
//  Out stall holds the result; the state registers are the output register.
//
module bidirectional_pwm_motor_drive
	import bpmd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic signed [7:0] speed,

	output logic              out_valid,
	input  logic              out_stall,
	output logic              drive_a,
	output logic              drive_b,
	output logic [8:0]        duty_a,
	output logic [8:0]        duty_b,

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// configuration registers
	logic [1:0]        cal_mode_q;
	logic signed [7:0] cal_reverse_q;
	logic signed [7:0] cal_forward_q;

	logic       cfg_write;
	logic [1:0] reg_index;

	assign pready    = 1'b1;
	assign reg_index = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_mode_q    <= MODE_SPLIT;
			cal_reverse_q <= '0;
			cal_forward_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_index)
				REG_CAL_MODE:    cal_mode_q    <= pwdata[1:0];
				REG_CAL_REVERSE: cal_reverse_q <= pwdata[7:0];
				REG_CAL_FORWARD: cal_forward_q <= pwdata[7:0];
				default:         ;  // beyond the register list: drop
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_CAL_MODE:    prdata = {30'd0, cal_mode_q};
			REG_CAL_REVERSE: prdata = {24'd0, cal_reverse_q};
			REG_CAL_FORWARD: prdata = {24'd0, cal_forward_q};
			default:         prdata = '0;
		endcase
	end

	// speed operands, all in 0..255 (or 1..128 for the negated speed)
	logic [8:0] speed_x, rev_x, fwd_x;
	logic [8:0] spd_rev, spd_fwd, spd_neg, span_rev, span_fwd;

	assign speed_x  = {speed[7], speed};
	assign rev_x    = {cal_reverse_q[7], cal_reverse_q};
	assign fwd_x    = {cal_forward_q[7], cal_forward_q};
	assign spd_rev  = 9'd127 - speed_x;
	assign spd_fwd  = 9'd128 + speed_x;
	assign spd_neg  = 9'd0 - speed_x;
	assign span_rev = 9'd127 - rev_x;
	assign span_fwd = 9'd128 + fwd_x;

	// sequencer
	ctl_state_t       state_q, state_n;
	logic             fwd_q, fwd_n;
	logic [MAG_W-1:0] mag_q, mag_n;
	logic             out_valid_q;
	logic             set_out;
	logic             accept;

	md_req_t  md_req;
	md_rsp_t  md_rsp;
	pwm_ctl_t pwm_ctl;
	pwm_sts_t pwm_sts;

	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			// a new result only arrives once the last one has left
			out_valid_q <= set_out || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		fwd_q <= fwd_n;
		mag_q <= mag_n;
	end

	always_comb begin
		state_n = state_q;
		fwd_n   = fwd_q;
		mag_n   = mag_q;
		set_out = 1'b0;
		md_req  = '0;
		pwm_ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (command == CMD_TICK) begin
						pwm_ctl.tick = 1'b1;
						set_out      = 1'b1;
					end else begin
						md_req.mult_b  = PERIOD_VAL;
						md_req.divisor = DIV_SPAN;
						unique case (cal_mode_q)
							MODE_SPLIT: begin
								if (speed == '0) begin
									// zero demand: both channels off
									pwm_ctl.load = 1'b1;
									set_out      = 1'b1;
								end else if (speed[7]) begin
									md_req.start  = 1'b1;
									md_req.mult_a = span_rev[MAG_W-1:0];
									fwd_n         = 1'b0;
									mag_n         = spd_neg[MAG_W-1:0];
									state_n       = ST_SPAN;
								end else begin
									md_req.start  = 1'b1;
									md_req.mult_a = span_fwd[MAG_W-1:0];
									fwd_n         = 1'b1;
									mag_n         = speed[MAG_W-1:0];
									state_n       = ST_SPAN;
								end
							end
							MODE_REV: begin
								md_req.start  = 1'b1;
								md_req.mult_a = spd_rev[MAG_W-1:0];
								fwd_n         = 1'b0;
								state_n       = ST_FINAL;
							end
							MODE_FWD: begin
								md_req.start  = 1'b1;
								md_req.mult_a = spd_fwd[MAG_W-1:0];
								fwd_n         = 1'b1;
								state_n       = ST_FINAL;
							end
							MODE_OFF: begin
								pwm_ctl.load = 1'b1;
								set_out      = 1'b1;
							end
							default: ;
						endcase
					end
				end
			end
			ST_SPAN: begin
				// span ready: scale the speed magnitude by it
				if (md_rsp.done) begin
					md_req.start   = 1'b1;
					md_req.mult_a  = mag_q;
					md_req.mult_b  = md_rsp.quot;
					md_req.divisor = fwd_q ? DIV_FWD : DIV_REV;
					state_n        = ST_FINAL;
				end
			end
			ST_FINAL: begin
				// steer the magnitude to one channel, zero the other
				if (md_rsp.done) begin
					pwm_ctl.load  = 1'b1;
					pwm_ctl.cmp_a = fwd_q ? md_rsp.quot : '0;
					pwm_ctl.cmp_b = fwd_q ? '0 : md_rsp.quot;
					set_out       = 1'b1;
					state_n       = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	bpmd_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	bpmd_pwm u_pwm (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pwm_ctl),
		.sts    (pwm_sts)
	);

	assign out_valid = out_valid_q;
	assign drive_a   = pwm_sts.pin_a;
	assign drive_b   = pwm_sts.pin_b;
	assign duty_a    = pwm_sts.cmp_a;
	assign duty_b    = pwm_sts.cmp_b;

endmodule

// File: rtl/bpmd_checker.sv
// ----------------------------------------------------------------------------
// bpmd_checker: port-level checks for the bidirectional PWM motor drive
// Watches the result channel and the tick path from the top-level ports.
// ----------------------------------------------------------------------------
module bpmd_checker
	import bpmd_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              command,
	input logic              out_valid,
	input logic              out_stall,
	input logic              drive_a,
	input logic              drive_b,
	input logic [8:0]        duty_a,
	input logic [8:0]        duty_b
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(duty_a) && $stable(duty_b)
			&& $stable(drive_a) && $stable(drive_b))
		else $error("stalled result changed");

	// only one channel carries a duty at a time
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty_a == '0) || (duty_b == '0))
		else $error("both channels driven");

	// duty never exceeds the period
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (duty_a <= PERIOD_VAL) && (duty_b <= PERIOD_VAL))
		else $error("duty beyond period");

	// a tick transfer yields its result on the next cycle
	a_tick_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == CMD_TICK) |=> out_valid)
		else $error("tick result late");

endmodule

bind bidirectional_pwm_motor_drive bpmd_checker u_checker (.*);
